// ===== sv/fms_pkg.sv =====
// ---------------------------------------------------------------------------
// fms_pkg
// Shared types, constants and the twiddle table for the magnitude spectrum.
// ---------------------------------------------------------------------------
`default_nettype none
package fms_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = 6;   // log2 of MAX_POINTS
  localparam int CNT_W      = 7;   // holds 0..MAX_POINTS
  localparam int ROOT_W     = 24;  // floor sqrt of a 48-bit sum of squares
  localparam int SQ_W       = 48;
  localparam int ACC_W      = 39;
  localparam int TW_W       = 18;
  localparam int PROD_W     = 34;

  localparam logic [2:0] LOG2_MIN   = 3'd2;
  localparam logic [2:0] LOG2_MAX   = 3'd6;
  localparam logic [2:0] LOG2_RESET = 3'd6;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] used;
    logic [2:0]       log2n;
    logic [3:0]       tag;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic       bank;
  } release_t;

  function automatic logic [2:0] eff_log2(input logic [2:0] v);
    logic [2:0] e;
    e = v;
    if (e < LOG2_MIN) e = LOG2_MIN;
    if (e > LOG2_MAX) e = LOG2_MAX;
    return e;
  endfunction

  function automatic logic signed [TW_W-1:0] quarter_cos(input logic [4:0] r);
    logic signed [TW_W-1:0] q;
    case (r)
      5'd0:    q = 18'sd65536;
      5'd1:    q = 18'sd65220;
      5'd2:    q = 18'sd64277;
      5'd3:    q = 18'sd62714;
      5'd4:    q = 18'sd60547;
      5'd5:    q = 18'sd57798;
      5'd6:    q = 18'sd54491;
      5'd7:    q = 18'sd50660;
      5'd8:    q = 18'sd46341;
      5'd9:    q = 18'sd41576;
      5'd10:   q = 18'sd36410;
      5'd11:   q = 18'sd30893;
      5'd12:   q = 18'sd25080;
      5'd13:   q = 18'sd19024;
      5'd14:   q = 18'sd12785;
      5'd15:   q = 18'sd6424;
      default: q = 18'sd0;
    endcase
    return q;
  endfunction

  function automatic logic signed [TW_W-1:0] tw_cos(input logic [5:0] j);
    logic [4:0] r;
    logic [4:0] rr;
    logic signed [TW_W-1:0] v;
    r  = {1'b0, j[3:0]};
    rr = 5'd16 - r;
    case (j[5:4])
      2'd0:    v = quarter_cos(r);
      2'd1:    v = -quarter_cos(rr);
      2'd2:    v = -quarter_cos(r);
      default: v = quarter_cos(rr);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/fms_queue.sv =====
// ---------------------------------------------------------------------------
// fms_queue
// Two-entry job queue between the loader and the transform engine.
// ---------------------------------------------------------------------------
`default_nettype none
module fms_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fms_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               avail,
  output fms_pkg::job_t      head
);
  import fms_pkg::*;

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        slots[wptr] <= push_job;
        wptr        <= ~wptr;
      end
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slots[rptr];

endmodule
`default_nettype wire

// ===== sv/fms_front.sv =====
// ---------------------------------------------------------------------------
// fms_front
// Sample loader: fills one of two sample banks and hands finished frames on.
// ---------------------------------------------------------------------------
`default_nettype none
module fms_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [2:0]              log2n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [15:0]      sample,
  input  wire logic                    frame_end,
  input  wire logic [3:0]              channel_tag,
  output logic                         push,
  output fms_pkg::job_t                push_job,
  input  wire logic                    q_full,
  input  wire fms_pkg::release_t       rel,
  input  wire logic [fms_pkg::ADDR_W:0] rd_addr,
  output logic signed [15:0]           rd_data
);
  import fms_pkg::*;

  logic signed [15:0] mem [2*MAX_POINTS];
  logic [CNT_W-1:0]   loaded_count;
  logic [3:0]         frame_tag;
  logic               wbank;
  logic [1:0]         busy;

  logic             take;
  logic [CNT_W-1:0] n_pts;
  logic             keep;
  logic [CNT_W-1:0] cnt_after;
  logic [3:0]       tag_now;

  assign in_stall = busy[wbank] | q_full;
  assign take     = in_valid & ~in_stall;
  assign n_pts    = CNT_W'(1) << log2n;
  assign keep     = loaded_count < n_pts;
  assign cnt_after = keep ? loaded_count + CNT_W'(1) : loaded_count;
  assign tag_now  = (loaded_count == '0) ? channel_tag : frame_tag;

  assign push           = take & frame_end;
  assign push_job.bank  = wbank;
  assign push_job.used  = (cnt_after < n_pts) ? cnt_after : n_pts;
  assign push_job.log2n = log2n;
  assign push_job.tag   = tag_now;

  always_ff @(posedge clk) begin
    if (take && keep) mem[{wbank, loaded_count[ADDR_W-1:0]}] <= sample;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      frame_tag    <= 4'd0;
      wbank        <= 1'b0;
      busy         <= 2'b00;
    end else begin
      if (rel.valid) busy[rel.bank] <= 1'b0;
      if (take) begin
        frame_tag <= tag_now;
        if (frame_end) begin
          loaded_count <= '0;
          busy[wbank]  <= 1'b1;
          wbank        <= ~wbank;
        end else begin
          loaded_count <= cnt_after;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/fms_back.sv =====
// ---------------------------------------------------------------------------
// fms_back
// Transform engine: per bin a pipelined DFT sum, squares, a bit-serial root.
// ---------------------------------------------------------------------------
`default_nettype none
module fms_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     q_avail,
  input  wire fms_pkg::job_t            q_head,
  output logic                          pop,
  output fms_pkg::release_t             rel,
  output logic [fms_pkg::ADDR_W:0]      rd_addr,
  input  wire logic signed [15:0]       rd_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [5:0]                    bin_index,
  output logic [15:0]                   magnitude,
  output logic [3:0]                    result_tag,
  output logic                          run_end
);
  import fms_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_MAC   = 8'b00000010,
    ST_DRAIN = 8'b00000100,
    ST_SQ    = 8'b00001000,
    ST_MUL   = 8'b00010000,
    ST_SUM   = 8'b00100000,
    ST_ROOT  = 8'b01000000,
    ST_OUT   = 8'b10000000
  } state_t;

  state_t st;
  job_t   job;
  logic [ADDR_W-1:0] k;
  logic [ADDR_W-1:0] step;
  logic [ADDR_W-1:0] j;
  logic [CNT_W-1:0]  n;

  logic              v1;
  logic [ADDR_W-1:0] j1;
  logic              pv;
  logic signed [PROD_W-1:0] p_re;
  logic signed [PROD_W-1:0] p_im;
  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;

  logic [ROOT_W-1:0] a;
  logic [ROOT_W-1:0] b;
  logic [SQ_W-1:0]   aa;
  logic [SQ_W-1:0]   bb;
  logic [SQ_W-1:0]   src;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W-1:0] root;
  logic [4:0]        root_cnt;

  logic              issue;
  logic [ADDR_W-1:0] last_k;
  logic [ADDR_W-1:0] stride;
  logic [ACC_W-1:0]  abs_re;
  logic [ACC_W-1:0]  abs_im;
  logic [3:0]        sh;
  logic [ROOT_W+1:0] trial_in;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W:0]   rounded;
  logic [16:0]       mag_raw;
  logic              out_free;

  assign issue    = (st == ST_MAC) && (n < job.used);
  assign rd_addr  = {job.bank, n[ADDR_W-1:0]};
  assign last_k   = ADDR_W'((CNT_W'(1) << job.log2n) - CNT_W'(1));
  assign stride   = ADDR_W'(CNT_W'(MAX_POINTS) >> job.log2n);
  assign abs_re   = acc_re[ACC_W-1] ? ACC_W'(-acc_re) : ACC_W'(acc_re);
  assign abs_im   = acc_im[ACC_W-1] ? ACC_W'(-acc_im) : ACC_W'(acc_im);
  assign sh       = 4'd8 + {1'b0, job.log2n};
  assign trial_in = {rem[ROOT_W-1:0], src[SQ_W-1 -: 2]};
  assign trial    = {1'b0, trial_in} - {1'b0, root, 2'b01};
  assign rounded  = {1'b0, root} + (ROOT_W+1)'(128);
  assign mag_raw  = rounded[ROOT_W:8];
  assign out_free = ~out_valid | ~out_stall;
  assign pop      = (st == ST_IDLE) && q_avail;
  assign rel.valid = (st == ST_OUT) && out_free && (k == last_k);
  assign rel.bank  = job.bank;

  // multiply-accumulate pipeline: memory read, products, sum
  always_ff @(posedge clk) begin
    j1   <= j;
    p_re <= PROD_W'(rd_data) * PROD_W'(tw_cos(j1));
    p_im <= PROD_W'(rd_data) * PROD_W'(tw_cos(j1 + 6'd48));
    if (pv) begin
      acc_re <= acc_re + ACC_W'(p_re);
      acc_im <= acc_im - ACC_W'(p_im);
    end
    if ((st == ST_IDLE) || ((st == ST_OUT) && out_free)) begin
      acc_re <= '0;
      acc_im <= '0;
    end
    a   <= ROOT_W'(abs_re >> sh);
    b   <= ROOT_W'(abs_im >> sh);
    aa  <= a * a;
    bb  <= b * b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      v1        <= 1'b0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= issue;
      pv <= v1;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (q_avail) begin
            job  <= q_head;
            k    <= '0;
            step <= '0;
            j    <= '0;
            n    <= '0;
            st   <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (issue) begin
            n <= n + CNT_W'(1);
            j <= j + step;
          end else begin
            st <= ST_DRAIN;
          end
        end
        ST_DRAIN: if (!v1 && !pv) st <= ST_SQ;
        ST_SQ:    st <= ST_MUL;
        ST_MUL:   st <= ST_SUM;
        ST_SUM: begin
          src      <= aa + bb;
          rem      <= '0;
          root     <= '0;
          root_cnt <= '0;
          st       <= ST_ROOT;
        end
        ST_ROOT: begin
          // one result bit per cycle, restoring form
          if (!trial[ROOT_W+2]) begin
            rem  <= trial[ROOT_W+1:0];
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= trial_in;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          src      <= src << 2;
          root_cnt <= root_cnt + 5'd1;
          if (root_cnt == 5'(ROOT_W-1)) st <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            bin_index  <= k;
            magnitude  <= (mag_raw > 17'd32768) ? 16'd32768 : mag_raw[15:0];
            result_tag <= job.tag;
            run_end    <= (k == last_k);
            if (k == last_k) begin
              st <= ST_IDLE;
            end else begin
              k    <= k + 6'd1;
              step <= step + stride;
              j    <= '0;
              n    <= '0;
              st   <= ST_MAC;
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable({bin_index, magnitude, result_tag, run_end})))
    else $error("bin payload changed while stalled");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SQ) |-> (!v1 && !pv))
    else $error("squares taken before the sum is complete");

  a_root_count: assert property (@(posedge clk) disable iff (rst)
    (st == ST_ROOT) |-> (root_cnt < 5'(ROOT_W)))
    else $error("root step count overrun");

  a_release: assert property (@(posedge clk) disable iff (rst)
    rel.valid |=> (out_valid && run_end && st == ST_IDLE))
    else $error("bank released without the final bin");

endmodule
`default_nettype wire

// ===== sv/fft_magnitude_spectrum.sv =====
// ---------------------------------------------------------------------------
// fft_magnitude_spectrum
// Frame loader, job queue and transform engine giving |X[k]|/N per bin.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | sample, frame_end, channel_tag
//  out     | out_valid/out_stall| bin_index, magnitude, result_tag, run_end
//  cfg     | cfg_valid/cfg_ready| log2_points
//
//  loading accepts one sample per cycle while in_stall is low; two sample
//  banks let the next frame load while the previous one is transformed
//  each bin runs the multiply-accumulate pass over the kept samples, then
//  drain, squares and a 24-step root
//  input stalls while both banks hold frames the engine has not finished
//  synchronous reset; configuration register resets to 6
`default_nettype none
module fft_magnitude_spectrum (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] sample,
  input  wire logic               frame_end,
  input  wire logic [3:0]         channel_tag,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              bin_index,
  output logic [15:0]             magnitude,
  output logic [3:0]              result_tag,
  output logic                    run_end,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         log2_points
);
  import fms_pkg::*;

  logic [2:0]        log2_reg;
  logic              push;
  job_t              push_job;
  logic              q_full;
  logic              pop;
  logic              q_avail;
  job_t              q_head;
  release_t          rel;
  logic [ADDR_W:0]   rd_addr;
  logic signed [15:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_reg <= LOG2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      log2_reg <= log2_points;
    end
  end

  fms_front u_front (
    .clk, .rst,
    .log2n(eff_log2(log2_reg)),
    .in_valid, .in_stall, .sample, .frame_end, .channel_tag,
    .push, .push_job, .q_full, .rel, .rd_addr, .rd_data
  );

  fms_queue u_queue (
    .clk, .rst, .push, .push_job, .full(q_full),
    .pop, .avail(q_avail), .head(q_head)
  );

  fms_back u_back (
    .clk, .rst, .q_avail, .q_head, .pop, .rel, .rd_addr, .rd_data,
    .out_valid, .out_stall, .bin_index, .magnitude, .result_tag, .run_end
  );

endmodule
`default_nettype wire

// ===== tb/fms_checker.sv =====
// ---------------------------------------------------------------------------
// fms_checker
// Watches the sample, spectrum and size channels of fft_magnitude_spectrum.
// Keeps its own copy of the frame state and the size register, computes the
// expected per-bin magnitudes for every completed frame and compares them
// with the bins the block sends out, in order.
// ---------------------------------------------------------------------------
module fms_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] sample,
  input  logic               frame_end,
  input  logic [3:0]         channel_tag,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [5:0]         bin_index,
  input  logic [15:0]        magnitude,
  input  logic [3:0]         result_tag,
  input  logic               run_end,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         log2_points,
  output int                 pending,
  output int                 mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]  bin;
    logic [15:0] mag;
    logic [3:0]  tag;
    logic        last;
  } bin_result_t;

  bin_result_t expected_bins[$];

  logic [2:0]         size_reg;
  logic signed [15:0] frame_samples[64];
  int                 kept;
  logic [3:0]         held_tag;
  int                 err_count;

  assign pending    = expected_bins.size();
  assign mismatches = err_count;

  // cos(2*pi*j/64) in Q1.16
  function automatic longint twiddle_cos(input int j);
    int q;
    int r;
    longint quarter[17];
    quarter = '{65536, 65220, 64277, 62714, 60547, 57798, 54491, 50660, 46341,
                41576, 36410, 30893, 25080, 19024, 12785, 6424, 0};
    j = j & 63;
    q = j >> 4;
    r = j & 15;
    case (q)
      0:       return quarter[r];
      1:       return -quarter[16 - r];
      2:       return -quarter[r];
      default: return quarter[16 - r];
    endcase
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic take_sample(input logic signed [15:0] s, input logic fe,
                             input logic [3:0] t);
    int              e;
    int              npts;
    int              stride;
    int              used;
    longint          re;
    longint          im;
    longint          x;
    longint unsigned a;
    longint unsigned b;
    longint unsigned root;
    longint unsigned m;
    int              j;
    bin_result_t     r;
    e = size_reg;
    if (e < 2) e = 2;
    if (e > 6) e = 6;
    npts   = 1 << e;
    stride = 64 >> e;
    if (kept == 0) held_tag = t;
    if (kept < npts) begin
      frame_samples[kept] = s;
      kept++;
    end
    if (!fe) return;
    used = (kept < npts) ? kept : npts;
    for (int k = 0; k < npts; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < used; n++) begin
        x  = frame_samples[n];
        j  = (n * k * stride) & 63;
        re = re + x * twiddle_cos(j);
        im = im - x * twiddle_cos(j + 48);
      end
      a    = ((re < 0) ? -re : re) >> (8 + e);
      b    = ((im < 0) ? -im : im) >> (8 + e);
      root = floor_sqrt(a * a + b * b);
      m    = (root + 128) >> 8;
      if (m > 32768) m = 32768;
      r.bin  = k[5:0];
      r.mag  = m[15:0];
      r.tag  = held_tag;
      r.last = (k == npts - 1);
      expected_bins.push_back(r);
    end
    kept = 0;
  endtask

  always @(posedge clk) begin
    bin_result_t exp_bin;
    if (rst) begin
      size_reg  = 3'd6;
      kept      = 0;
      held_tag  = 4'd0;
      err_count = 0;
      expected_bins.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bins.size() == 0) begin
          $error("bin transfer with nothing expected: bin_index %0d", bin_index);
          err_count++;
        end else begin
          exp_bin = expected_bins.pop_front();
          if (bin_index !== exp_bin.bin) begin
            $error("bin_index: expected %0d, got %0d", exp_bin.bin, bin_index);
            err_count++;
          end
          if (magnitude !== exp_bin.mag) begin
            $error("magnitude: expected %0d, got %0d", exp_bin.mag, magnitude);
            err_count++;
          end
          if (result_tag !== exp_bin.tag) begin
            $error("result_tag: expected %0d, got %0d", exp_bin.tag, result_tag);
            err_count++;
          end
          if (run_end !== exp_bin.last) begin
            $error("run_end: expected %0d, got %0d", exp_bin.last, run_end);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) take_sample(sample, frame_end, channel_tag);
      if (cfg_valid && cfg_ready) size_reg = log2_points;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Stimulus for fft_magnitude_spectrum: directed frames at the extremes of
// size and sample range, then random frames under random idling, a long
// output hold-off and size changes while idle. fms_checker does the scoring.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 410;
  localparam int STALL_LIMIT = 40000;
  localparam int HOLD_CYCLES = 2500;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] sample;
  logic               frame_end;
  logic [3:0]         channel_tag;
  logic               out_valid;
  logic               out_stall;
  logic [5:0]         bin_index;
  logic [15:0]        magnitude;
  logic [3:0]         result_tag;
  logic               run_end;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         log2_points;

  int pending;
  int mismatches;
  int samples_sent;
  int quiet_cycles;
  bit quiet;
  bit hold_go;
  bit hold_done;

  fft_magnitude_spectrum DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .frame_end(frame_end), .channel_tag(channel_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_index(bin_index), .magnitude(magnitude),
    .result_tag(result_tag), .run_end(run_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .log2_points(log2_points)
  );

  fms_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .frame_end(frame_end), .channel_tag(channel_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_index(bin_index), .magnitude(magnitude),
    .result_tag(result_tag), .run_end(run_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .log2_points(log2_points),
    .pending(pending), .mismatches(mismatches)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // output side: random stalls, one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= !rst && !quiet && ($urandom_range(0, 99) < 11);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [15:0] s, input logic fe,
                             input logic [3:0] t);
    bit ok;
    if (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    frame_end   <= fe;
    channel_tag <= t;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    samples_sent++;
  endtask

  // waits for the spectrum to drain, then lets the engine settle
  task automatic drain;
    in_valid <= 1'b0;
    // let the checker score the last transfer first
    @(negedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_size(input logic [2:0] v);
    bit ok;
    drain();
    cfg_valid   <= 1'b1;
    log2_points <= v;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample;
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return $signed(16'($urandom_range(0, 255))) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int len, input logic [3:0] t);
    for (int i = 0; i < len; i++) begin
      // later samples carry a random tag, which is ignored
      send_sample(pick_sample(), i == len - 1, (i == 0) ? t : 4'($urandom));
    end
  endtask

  function automatic logic [2:0] pick_size;
    int r;
    r = $urandom_range(0, 19);
    if (r < 9)  return 3'd2;
    if (r < 14) return 3'd3;
    if (r < 16) return 3'd4;
    if (r == 16) return 3'($urandom_range(0, 1));
    if (r == 17) return 3'd7;
    if (r == 18) return 3'd5;
    return 3'd6;
  endfunction

  initial begin
    int npts;
    int len;
    bit paused;
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample       = '0;
    frame_end    = 1'b0;
    channel_tag  = '0;
    cfg_valid    = 1'b0;
    log2_points  = 3'd6;
    quiet        = 1'b0;
    hold_go      = 1'b0;
    samples_sent = 0;
    paused       = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // size after reset: one sample padded to 64 points
    send_sample(16'sh7FFF, 1'b1, 4'd15);
    // smallest size: full-scale negative dc saturates bin 0
    write_size(3'd2);
    for (int i = 0; i < 4; i++) send_sample(16'sh8000, i == 3, 4'd9);
    // alternating extremes, frame longer than n ends on a dropped sample
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7FFF, i == 5, 4'd6);
    // below-range size clamps up
    write_size(3'd0);
    for (int i = 0; i < 3; i++) send_sample(16'sd0, i == 2, 4'd0);
    // above-range size clamps down, size changed in the middle of a frame
    write_size(3'd7);
    send_sample(16'sd1, 1'b0, 4'd3);
    send_sample(-16'sd1, 1'b0, 4'd12);
    write_size(3'd1);
    send_sample(16'sh4000, 1'b1, 4'd5);
    write_size(3'd3);
    for (int i = 0; i < 5; i++) send_sample(pick_sample(), i == 4, 4'($urandom));

    while (samples_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 5) == 0) write_size(pick_size());
      if (!hold_go && samples_sent > 120) hold_go = 1'b1;
      if (!paused && samples_sent > 330) begin
        drain();
        paused = 1'b1;
      end
      quiet = (samples_sent > 200 && samples_sent < 280);
      npts  = 1 << ((u_checker.size_reg < 2) ? 2 :
                    (u_checker.size_reg > 6) ? 6 : u_checker.size_reg);
      len   = ($urandom_range(0, 6) == 0) ? $urandom_range(npts + 1, npts + 4)
                                          : $urandom_range(1, npts);
      send_frame(len, 4'($urandom));
    end
    quiet = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
